// File: design/plist_pkg.sv
// Shared types, request and status codes for the positional list engine.
`default_nettype none

package plist_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int CNT_OUT_W    = 7;
  localparam int REQ_W        = 2;
  localparam int ST_W         = 2;

  localparam logic [REQ_W-1:0] OP_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] OP_READ   = 2'd2;
  localparam logic [REQ_W-1:0] OP_WRITE  = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // Broadcast to every cell in the chain for one accepted word.
  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/plist_cell.sv
// One storage cell of the list chain: holds one element, shifts with its neighbors.
`default_nettype none

module plist_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  wire logic                        clk,
  input  wire plist_pkg::cmd_t             cmd,
  input  wire logic [PW-1:0]               pos,
  input  wire logic [plist_pkg::DATA_W-1:0] value,
  input  wire logic [plist_pkg::DATA_W-1:0] left,
  input  wire logic [plist_pkg::DATA_W-1:0] right,
  output logic      [plist_pkg::DATA_W-1:0] cur,
  output logic      [plist_pkg::DATA_W-1:0] nxt,
  output logic      [plist_pkg::DATA_W-1:0] tap
);

  logic hit;
  logic above;

  always_comb begin
    hit   = (pos == PW'(IDX));
    above = (pos < PW'(IDX));
    nxt   = cur;
    // insert: cells past the slot take their left neighbor, the slot takes the value
    if (cmd.ins) begin
      if (above) begin
        nxt = left;
      end else if (hit) begin
        nxt = value;
      end
    end
    // remove: the slot and everything after it pull from the right
    if (cmd.rem && (above || hit)) begin
      nxt = right;
    end
    if (cmd.wr && hit) begin
      nxt = value;
    end
    tap = hit ? cur : '0;
  end

  always_ff @(posedge clk) begin
    cur <= nxt;
  end

endmodule

`default_nettype wire

// File: design/positional_list_engine.sv
// Top level of the positional list engine: request decode, cell chain, result register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_type, position, value
//   rsp     | out       | rsp_valid/rsp_stall  | status, data_out, element_count,
//           |           |                      | list_empty, front_value
//
// Per request: all cells shift or load in parallel from a position
// compare in the accept cycle, and the result lands in the output register.
// A new request is taken every cycle while the result register is free or drained.
// rst clears the element count and the result valid; cell contents are not reset.
// req_stall is high while a result is held by rsp_stall.
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic [plist_pkg::REQ_W-1:0]         req_type,
  input  wire logic [plist_pkg::POS_W-1:0]         position,
  input  wire logic signed [plist_pkg::DATA_W-1:0] value,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output logic      [plist_pkg::ST_W-1:0]          status,
  output logic signed [plist_pkg::DATA_W-1:0]      data_out,
  output logic      [plist_pkg::CNT_OUT_W-1:0]     element_count,
  output logic                                     list_empty,
  output logic signed [plist_pkg::DATA_W-1:0]      front_value
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > plist_pkg::POS_W) ? CNT_W : plist_pkg::POS_W;
  localparam int DW    = plist_pkg::DATA_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] eff_pos;
  logic             is_empty;
  logic             is_full;
  logic             pos_lt;
  logic             pos_le;

  plist_pkg::cmd_t      cmd;
  plist_pkg::cmd_t      cmd_gated;
  logic [plist_pkg::ST_W-1:0] st_next;
  logic                 want_data;

  logic [DW-1:0] cur  [CAPACITY];
  logic [DW-1:0] nxt  [CAPACITY];
  logic [DW-1:0] taps [CAPACITY];
  logic [DW-1:0] rd_any;

  assign accept    = req_valid && !req_stall;
  assign req_stall = rsp_valid && rsp_stall;

  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(count);
  assign is_empty = (count == '0);
  assign is_full  = (cnt_ext >= CMP_W'(CAPACITY));
  assign pos_lt   = (pos_ext < cnt_ext);
  assign pos_le   = (pos_ext <= cnt_ext);

  always_comb begin
    cmd       = '0;
    st_next   = plist_pkg::ST_DONE;
    want_data = 1'b0;
    eff_pos   = pos_ext;
    unique case (req_type)
      plist_pkg::OP_INSERT: begin
        if (is_empty) begin
          // an empty list always takes the value at the front
          eff_pos = '0;
          cmd.ins = 1'b1;
        end else if (is_full) begin
          st_next = plist_pkg::ST_FULL;
        end else if (!pos_le) begin
          st_next = plist_pkg::ST_RANGE;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      plist_pkg::OP_REMOVE: begin
        if (!pos_lt) begin
          st_next = plist_pkg::ST_RANGE;
        end else begin
          cmd.rem   = 1'b1;
          want_data = 1'b1;
        end
      end
      plist_pkg::OP_READ: begin
        if (!pos_lt) begin
          st_next = plist_pkg::ST_RANGE;
        end else begin
          want_data = 1'b1;
        end
      end
      plist_pkg::OP_WRITE: begin
        if (!pos_lt) begin
          st_next = plist_pkg::ST_RANGE;
        end else begin
          cmd.wr = 1'b1;
        end
      end
      default: begin
        st_next = plist_pkg::ST_RANGE;
      end
    endcase
  end

  assign cmd_gated = accept ? cmd : '0;

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_w;
    logic [DW-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cur[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cur[i+1];
    end

    plist_cell #(
      .IDX (i),
      .PW  (CMP_W)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd_gated),
      .pos   (eff_pos),
      .value (value),
      .left  (left_w),
      .right (right_w),
      .cur   (cur[i]),
      .nxt   (nxt[i]),
      .tap   (taps[i])
    );
  end

  // only the addressed cell drives a nonzero tap
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= st_next;
      data_out      <= want_data ? rd_any : '0;
      element_count <= plist_pkg::CNT_OUT_W'(count_next);
      list_empty    <= (count_next == '0);
      front_value   <= (count_next == '0) ? '0 : nxt[0];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.ins) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the list by one");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (list_empty == (element_count == '0)))
    else $error("empty flag disagrees with element count");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status != plist_pkg::ST_DONE)) |-> (data_out == '0))
    else $error("failed request returned data");
`endif

endmodule

`default_nettype wire
